[sv/rvex_pkg.sv]
package rvex_pkg;

    // Architectural sizes
    localparam int REG_COUNT = 32;

    // Command codes carried by the action field
    localparam logic [1:0] ACT_STEP    = 2'd0;
    localparam logic [1:0] ACT_RESTART = 2'd1;
    localparam logic [1:0] ACT_LOAD    = 2'd2;
    localparam logic [1:0] ACT_READ    = 2'd3;

    // Result status codes
    localparam logic [3:0] ST_ADV      = 4'd0;
    localparam logic [3:0] ST_HALT     = 4'd1;
    localparam logic [3:0] ST_EXIT     = 4'd2;
    localparam logic [3:0] ST_TRAP     = 4'd3;
    localparam logic [3:0] ST_FFAULT   = 4'd4;
    localparam logic [3:0] ST_LFAULT   = 4'd5;
    localparam logic [3:0] ST_SFAULT   = 4'd6;
    localparam logic [3:0] ST_ILLEGAL  = 4'd7;
    localparam logic [3:0] ST_ECALL    = 4'd8;
    localparam logic [3:0] ST_NOTREADY = 4'd9;

    // Run state
    localparam logic [1:0] RUN_IDLE   = 2'd0;
    localparam logic [1:0] RUN_READY  = 2'd1;
    localparam logic [1:0] RUN_EXITED = 2'd2;

    // Major opcodes
    localparam logic [6:0] OPC_LUI    = 7'h37;
    localparam logic [6:0] OPC_AUIPC  = 7'h17;
    localparam logic [6:0] OPC_OPIMM  = 7'h13;
    localparam logic [6:0] OPC_OP     = 7'h33;
    localparam logic [6:0] OPC_LOAD   = 7'h03;
    localparam logic [6:0] OPC_STORE  = 7'h23;
    localparam logic [6:0] OPC_JAL    = 7'h6f;
    localparam logic [6:0] OPC_JALR   = 7'h67;
    localparam logic [6:0] OPC_BRANCH = 7'h63;
    localparam logic [6:0] OPC_SYSTEM = 7'h73;

    // funct7 values
    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // ALU funct3
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // M extension funct3
    localparam logic [2:0] MD_MUL    = 3'd0;
    localparam logic [2:0] MD_MULH   = 3'd1;
    localparam logic [2:0] MD_MULHSU = 3'd2;
    localparam logic [2:0] MD_MULHU  = 3'd3;

    // Load and store funct3
    localparam logic [2:0] LD_B  = 3'd0;
    localparam logic [2:0] LD_H  = 3'd1;
    localparam logic [2:0] LD_W  = 3'd2;
    localparam logic [2:0] LD_BU = 3'd4;
    localparam logic [2:0] LD_HU = 3'd5;

    // Access sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;

    // Branch funct3
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // SYSTEM funct3
    localparam logic [2:0] SYS_PRIV  = 3'd0;
    localparam logic [2:0] SYS_RSVD  = 3'd4;
    localparam logic [1:0] CSR_RW    = 2'd1;
    localparam logic [1:0] CSR_RS    = 2'd2;

    // Whole-word SYSTEM encodings
    localparam logic [31:0] INSN_EBREAK = 32'h0010_0073;
    localparam logic [31:0] INSN_ECALL  = 32'h0000_0073;
    localparam logic [31:0] INSN_MRET   = 32'h3020_0073;

    // Machine CSR addresses
    localparam logic [11:0] CSR_MSTATUS = 12'h300;
    localparam logic [11:0] CSR_MTVEC   = 12'h305;
    localparam logic [11:0] CSR_MEPC    = 12'h341;
    localparam logic [11:0] CSR_MCAUSE  = 12'h342;
    localparam logic [11:0] CSR_MTVAL   = 12'h343;

    localparam logic [31:0] CAUSE_ILLEGAL = 32'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ENTRY    = 2'd0;
    localparam logic [1:0] CFG_STACK    = 2'd1;
    localparam logic [1:0] CFG_TOHOST   = 2'd2;
    localparam logic [1:0] CFG_FROMHOST = 2'd3;

    // Request to the multiply/divide unit
    typedef struct packed {
        logic       go;
        logic [2:0] funct3;
    } md_req_t;

    function automatic logic [31:0] imm_i(input logic [31:0] x);
        return {{20{x[31]}}, x[31:20]};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] x);
        return {{20{x[31]}}, x[31:25], x[11:7]};
    endfunction

    function automatic logic [31:0] imm_b(input logic [31:0] x);
        return {{19{x[31]}}, x[31], x[7], x[30:25], x[11:8], 1'b0};
    endfunction

    function automatic logic [31:0] imm_j(input logic [31:0] x);
        return {{11{x[31]}}, x[31], x[19:12], x[20], x[30:21], 1'b0};
    endfunction

    function automatic logic [2:0] size_bytes(input logic [1:0] sz);
        case (sz)
            SZ_BYTE: return 3'd1;
            SZ_HALF: return 3'd2;
            default: return 3'd4;
        endcase
    endfunction

    // Byte lanes of an access within a two-word window
    function automatic logic [7:0] byte_mask(input logic [1:0] sz, input logic [1:0] off);
        logic [7:0] base;
        case (sz)
            SZ_BYTE: base = 8'h01;
            SZ_HALF: base = 8'h03;
            default: base = 8'h0f;
        endcase
        return base << off;
    endfunction

    function automatic logic [31:0] window_align(input logic [63:0] win,
                                                 input logic [1:0] off);
        logic [63:0] s;
        s = win >> {off, 3'b000};
        return s[31:0];
    endfunction

    function automatic logic [31:0] load_format(input logic [31:0] r, input logic [2:0] f3);
        case (f3)
            LD_B:    return {{24{r[7]}}, r[7:0]};
            LD_H:    return {{16{r[15]}}, r[15:0]};
            LD_BU:   return {24'b0, r[7:0]};
            LD_HU:   return {16'b0, r[15:0]};
            default: return r;
        endcase
    endfunction

    function automatic logic [63:0] window_merge(input logic [63:0] old,
                                                 input logic [31:0] data,
                                                 input logic [1:0]  off,
                                                 input logic [7:0]  mask);
        logic [63:0] sh;
        logic [63:0] res;
        sh = {32'b0, data} << {off, 3'b000};
        for (int i = 0; i < 8; i++) begin
            res[8*i +: 8] = mask[i] ? sh[8*i +: 8] : old[8*i +: 8];
        end
        return res;
    endfunction

endpackage

[sv/rvex_mem.sv]
module rvex_mem #(
    parameter int MEM_WORDS = 16384,
    parameter int ADDR_W    = 14
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [31:0]       wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [31:0]       rdata
);

    logic [31:0] mem [MEM_WORDS];
    logic [31:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/rvex_regfile.sv]
module rvex_regfile import rvex_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        clear,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);

    logic [31:0]          regs [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [REG_COUNT-1:0] valid_next;
    logic [31:0]          data_a_reg;
    logic [31:0]          data_b_reg;
    logic                 vld_a_reg;
    logic                 vld_b_reg;
    logic                 wr_en;

    // x0 is never written, so its valid bit stays clear
    assign wr_en = we && (waddr != 5'd0);

    always_comb
    begin
        valid_next = clear ? '0 : valid_reg;
        if (wr_en)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    // Hold per-entry valid bits; an invalid entry reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            vld_a_reg <= valid_reg[raddr_a];
            vld_b_reg <= valid_reg[raddr_b];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            regs[waddr] <= wdata;
        end
        data_a_reg <= regs[raddr_a];
        data_b_reg <= regs[raddr_b];
    end

    assign rdata_a = vld_a_reg ? data_a_reg : 32'd0;
    assign rdata_b = vld_b_reg ? data_b_reg : 32'd0;

endmodule

[sv/rvex_muldiv.sv]
module rvex_muldiv import rvex_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  md_req_t     req,
    input  logic [31:0] op_a,
    input  logic [31:0] op_b,
    output logic        done,
    output logic [31:0] value
);

    localparam logic [1:0] P_IDLE = 2'd0;
    localparam logic [1:0] P_MUL  = 2'd1;
    localparam logic [1:0] P_DIV  = 2'd2;

    logic [1:0]  phase_reg, phase_next;
    logic [4:0]  count_reg, count_next;
    logic [2:0]  f3_reg, f3_next;
    logic [63:0] prod_reg, prod_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [31:0] dvs_reg, dvs_next;
    logic        negq_reg, negq_next;
    logic        negr_reg, negr_next;
    logic [31:0] value_reg, value_next;
    logic        done_reg, done_next;

    logic        sgn_a, sgn_b, div_sgn, an, bn;
    logic [65:0] prod_full;
    logic [32:0] r_sh, diff;

    always_comb
    begin
        phase_next = phase_reg;
        count_next = count_reg;
        f3_next    = f3_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        negq_next  = negq_reg;
        negr_next  = negr_reg;
        value_next = value_reg;
        done_next  = 1'b0;

        sgn_a     = (req.funct3 == MD_MULH) || (req.funct3 == MD_MULHSU);
        sgn_b     = (req.funct3 == MD_MULH);
        prod_full = $signed({sgn_a & op_a[31], op_a}) * $signed({sgn_b & op_b[31], op_b});
        div_sgn   = !req.funct3[0];
        an        = div_sgn & op_a[31];
        bn        = div_sgn & op_b[31];
        r_sh      = {rem_reg, quo_reg[31]};
        diff      = r_sh - {1'b0, dvs_reg};

        case (phase_reg)
            P_IDLE:
            begin
                if (req.go)
                begin
                    f3_next = req.funct3;
                    if (!req.funct3[2])
                    begin
                        // Register the product, select the half next cycle
                        prod_next  = prod_full[63:0];
                        phase_next = P_MUL;
                    end
                    else if (op_b == 32'd0)
                    begin
                        value_next = req.funct3[1] ? op_a : 32'hffff_ffff;
                        done_next  = 1'b1;
                    end
                    else if (div_sgn && op_a == 32'h8000_0000 && op_b == 32'hffff_ffff)
                    begin
                        value_next = req.funct3[1] ? 32'd0 : op_a;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        quo_next   = an ? 32'd0 - op_a : op_a;
                        dvs_next   = bn ? 32'd0 - op_b : op_b;
                        rem_next   = 32'd0;
                        negq_next  = an ^ bn;
                        negr_next  = an;
                        count_next = 5'd0;
                        phase_next = P_DIV;
                    end
                end
            end
            P_MUL:
            begin
                value_next = (f3_reg == MD_MUL) ? prod_reg[31:0] : prod_reg[63:32];
                done_next  = 1'b1;
                phase_next = P_IDLE;
            end
            P_DIV:
            begin
                // One restoring step a cycle
                if (!diff[32])
                begin
                    rem_next = diff[31:0];
                    quo_next = {quo_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next = r_sh[31:0];
                    quo_next = {quo_reg[30:0], 1'b0};
                end
                count_next = count_reg + 5'd1;
                if (count_reg == 5'd31)
                begin
                    if (f3_reg[1])
                    begin
                        value_next = negr_reg ? 32'd0 - rem_next : rem_next;
                    end
                    else
                    begin
                        value_next = negq_reg ? 32'd0 - quo_next : quo_next;
                    end
                    done_next  = 1'b1;
                    phase_next = P_IDLE;
                end
            end
            default:
            begin
                phase_next = P_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_IDLE;
            done_reg  <= 1'b0;
            count_reg <= 5'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f3_reg    <= f3_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        dvs_reg   <= dvs_next;
        negq_reg  <= negq_next;
        negr_reg  <= negr_next;
        value_reg <= value_next;
    end

    assign done  = done_reg;
    assign value = value_reg;

endmodule

[sv/rv32im_execute_core.sv]
// Sequence: load-word and restart finish from idle; a register read adds a read state; a step
// fetches (a second word when the pc is not word aligned), then executes; loads and stores read
// one or two words, a mailbox clear adds a further pass, and divide runs on the radix-2 divider.
// Throughput: one transaction at a time; busy is high until its result strobe.
// Reset: control, CSRs, configuration and register-file valid bits clear; local
// memory holds unknown data until written. done pulses one cycle; no stall.
module rv32im_execute_core import rvex_pkg::*; #(
    parameter int MEM_WORDS = 16384
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  action,
    input  logic [15:0] location,
    input  logic [31:0] word,
    output logic        done,
    output logic [3:0]  status,
    output logic [31:0] program_counter,
    output logic [4:0]  dest_index,
    output logic [31:0] result_value,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int          ADDR_W    = $clog2(MEM_WORDS);
    localparam logic [32:0] MEM_BYTES = 33'(MEM_WORDS) * 33'd4;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RDREG  = 4'd1;
    localparam logic [3:0] S_FETCH1 = 4'd2;
    localparam logic [3:0] S_FETCH2 = 4'd3;
    localparam logic [3:0] S_EXEC   = 4'd4;
    localparam logic [3:0] S_MULDIV = 4'd5;
    localparam logic [3:0] S_LD1    = 4'd6;
    localparam logic [3:0] S_LD2    = 4'd7;
    localparam logic [3:0] S_ST1    = 4'd8;
    localparam logic [3:0] S_ST2    = 4'd9;
    localparam logic [3:0] S_CLR    = 4'd10;

    function automatic logic mem_ok(input logic [31:0] a, input logic [2:0] n);
        return ({1'b0, a} + {30'b0, n}) <= MEM_BYTES;
    endfunction

    logic [3:0]  state_reg, state_next;
    logic [1:0]  run_reg, run_next;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] mstatus_reg, mstatus_next;
    logic [31:0] mtvec_reg, mtvec_next;
    logic [31:0] mepc_reg, mepc_next;
    logic [31:0] mcause_reg, mcause_next;
    logic [31:0] mtval_reg, mtval_next;
    logic [31:0] entry_reg, stack_reg, tohost_reg, fromhost_reg;
    logic [31:0] instr_reg, instr_next;
    logic [31:0] w0_reg, w0_next;
    logic        loc_ok_reg, loc_ok_next;
    logic [31:0] acc_addr_reg, acc_addr_next;
    logic [7:0]  acc_mask_reg, acc_mask_next;
    logic [2:0]  acc_f3_reg, acc_f3_next;
    logic [31:0] st_data_reg, st_data_next;
    logic        clr_pass_reg, clr_pass_next;
    logic        done_reg, done_next;
    logic [3:0]  status_reg, status_next;
    logic [4:0]  dest_reg, dest_next;
    logic [31:0] value_reg, value_next;

    // Memory and register-file ports
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [31:0]       mem_wdata, mem_rdata;
    logic              rf_we, rf_clear;
    logic [4:0]        rf_waddr, rf_raddr_a, rf_raddr_b;
    logic [31:0]       rf_wdata, rf_rdata_a, rf_rdata_b;
    md_req_t           md_req;
    logic              md_done;
    logic [31:0]       md_value;

    // Decode and sequencing temporaries
    logic [31:0] fetch_instr, x, a, b, npc, alu_v, ld_addr, st_addr, csr_old, csr_src, csr_new;
    logic [6:0]  opc, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic        taken, csr_wr;
    logic [ADDR_W-1:0] pc_idx, acc_idx, acc_idx1;
    logic [63:0] win;
    logic        fin, wb_en, st_end;
    logic [3:0]  fin_status;
    logic [4:0]  fin_dest;
    logic [31:0] fin_value, wb_val;

    assign pc_idx   = pc_reg[ADDR_W+1:2];
    assign acc_idx  = acc_addr_reg[ADDR_W+1:2];
    assign acc_idx1 = acc_idx + ADDR_W'(1);

    // Fetched word: direct when aligned, else stitched from two words
    assign fetch_instr = (state_reg == S_FETCH2)
                       ? window_align({mem_rdata, w0_reg}, pc_reg[1:0]) : mem_rdata;
    assign rf_raddr_a  = (state_reg == S_IDLE) ? location[4:0] : fetch_instr[19:15];
    assign rf_raddr_b  = fetch_instr[24:20];

    assign x   = instr_reg;
    assign opc = x[6:0];
    assign rd  = x[11:7];
    assign f3  = x[14:12];
    assign rs1 = x[19:15];
    assign rs2 = x[24:20];
    assign f7  = x[31:25];
    assign a   = rf_rdata_a;
    assign b   = rf_rdata_b;
    assign npc = pc_reg + 32'd4;
    assign ld_addr = a + imm_i(x);
    assign st_addr = a + imm_s(x);

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        run_next      = run_reg;
        pc_next       = pc_reg;
        mstatus_next  = mstatus_reg;
        mtvec_next    = mtvec_reg;
        mepc_next     = mepc_reg;
        mcause_next   = mcause_reg;
        mtval_next    = mtval_reg;
        instr_next    = instr_reg;
        w0_next       = w0_reg;
        loc_ok_next   = loc_ok_reg;
        acc_addr_next = acc_addr_reg;
        acc_mask_next = acc_mask_reg;
        acc_f3_next   = acc_f3_reg;
        st_data_next  = st_data_reg;
        clr_pass_next = clr_pass_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        dest_next     = dest_reg;
        value_next    = value_reg;

        mem_we     = 1'b0;
        mem_waddr  = acc_idx;
        mem_wdata  = 32'd0;
        mem_raddr  = pc_idx;
        rf_we      = 1'b0;
        rf_clear   = 1'b0;
        rf_waddr   = rd;
        rf_wdata   = 32'd0;
        md_req     = '0;

        fin        = 1'b0;
        fin_status = ST_ADV;
        fin_dest   = 5'd0;
        fin_value  = 32'd0;
        wb_en      = 1'b0;
        wb_val     = 32'd0;
        st_end     = 1'b0;
        alu_v      = 32'd0;
        taken      = 1'b0;
        csr_old    = 32'd0;
        csr_src    = 32'd0;
        csr_new    = 32'd0;
        csr_wr     = 1'b0;
        win        = 64'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (action)
                        ACT_STEP:
                        begin
                            if (run_reg != RUN_READY)
                            begin
                                fin        = 1'b1;
                                fin_status = ST_NOTREADY;
                            end
                            else if (!mem_ok(pc_reg, 3'd4))
                            begin
                                fin        = 1'b1;
                                fin_status = ST_FFAULT;
                            end
                            else
                            begin
                                state_next = S_FETCH1;
                            end
                        end
                        ACT_RESTART:
                        begin
                            rf_clear     = 1'b1;
                            rf_we        = 1'b1;
                            rf_waddr     = 5'd2;
                            rf_wdata     = {stack_reg[31:4], 4'b0000};
                            mstatus_next = 32'd0;
                            mtvec_next   = 32'd0;
                            mepc_next    = 32'd0;
                            mcause_next  = 32'd0;
                            mtval_next   = 32'd0;
                            pc_next      = entry_reg;
                            run_next     = RUN_READY;
                            fin          = 1'b1;
                        end
                        ACT_LOAD:
                        begin
                            if ({18'b0, location[15:2]} < 32'(MEM_WORDS))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = ADDR_W'({16'b0, location} >> 2);
                                mem_wdata = word;
                            end
                            fin       = 1'b1;
                            fin_value = word;
                        end
                        default:
                        begin
                            loc_ok_next = (location < 16'd32);
                            state_next  = S_RDREG;
                        end
                    endcase
                end
            end
            S_RDREG:
            begin
                fin       = 1'b1;
                fin_value = loc_ok_reg ? rf_rdata_a : 32'd0;
            end
            S_FETCH1:
            begin
                if (pc_reg[1:0] == 2'b00)
                begin
                    instr_next = fetch_instr;
                    state_next = S_EXEC;
                end
                else
                begin
                    w0_next    = mem_rdata;
                    mem_raddr  = pc_idx + ADDR_W'(1);
                    state_next = S_FETCH2;
                end
            end
            S_FETCH2:
            begin
                instr_next = fetch_instr;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                case (opc)
                    OPC_LUI:
                    begin
                        wb_en   = 1'b1;
                        wb_val  = {x[31:12], 12'b0};
                        pc_next = npc;
                        fin     = 1'b1;
                    end
                    OPC_AUIPC:
                    begin
                        wb_en   = 1'b1;
                        wb_val  = pc_reg + {x[31:12], 12'b0};
                        pc_next = npc;
                        fin     = 1'b1;
                    end
                    OPC_OPIMM:
                    begin
                        case (f3)
                            F3_ADD:  alu_v = a + imm_i(x);
                            F3_SLL:  alu_v = a << rs2;
                            F3_SLT:  alu_v = {31'b0, $signed(a) < $signed(imm_i(x))};
                            F3_SLTU: alu_v = {31'b0, a < imm_i(x)};
                            F3_XOR:  alu_v = a ^ imm_i(x);
                            F3_SR:   alu_v = (f7 == F7_ALT) ? 32'($signed(a) >>> rs2) : a >> rs2;
                            F3_OR:   alu_v = a | imm_i(x);
                            default: alu_v = a & imm_i(x);
                        endcase
                        fin = 1'b1;
                        if (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)
                        begin
                            fin_status = ST_ILLEGAL;
                        end
                        else
                        begin
                            wb_en   = 1'b1;
                            wb_val  = alu_v;
                            pc_next = npc;
                        end
                    end
                    OPC_OP:
                    begin
                        if (f7 == F7_MULDIV)
                        begin
                            md_req.go     = 1'b1;
                            md_req.funct3 = f3;
                            state_next    = S_MULDIV;
                        end
                        else if (f7 == F7_BASE)
                        begin
                            case (f3)
                                F3_ADD:  alu_v = a + b;
                                F3_SLL:  alu_v = a << b[4:0];
                                F3_SLT:  alu_v = {31'b0, $signed(a) < $signed(b)};
                                F3_SLTU: alu_v = {31'b0, a < b};
                                F3_XOR:  alu_v = a ^ b;
                                F3_SR:   alu_v = a >> b[4:0];
                                F3_OR:   alu_v = a | b;
                                default: alu_v = a & b;
                            endcase
                            wb_en   = 1'b1;
                            wb_val  = alu_v;
                            pc_next = npc;
                            fin     = 1'b1;
                        end
                        else if (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))
                        begin
                            wb_en   = 1'b1;
                            wb_val  = (f3 == F3_ADD) ? a - b : 32'($signed(a) >>> b[4:0]);
                            pc_next = npc;
                            fin     = 1'b1;
                        end
                        else
                        begin
                            fin        = 1'b1;
                            fin_status = ST_ILLEGAL;
                        end
                    end
                    OPC_LOAD:
                    begin
                        if (f3 == 3'd3 || f3 > LD_HU)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_ILLEGAL;
                        end
                        else if (!mem_ok(ld_addr, size_bytes(f3[1:0])))
                        begin
                            fin        = 1'b1;
                            fin_status = ST_LFAULT;
                        end
                        else
                        begin
                            acc_addr_next = ld_addr;
                            acc_mask_next = byte_mask(f3[1:0], ld_addr[1:0]);
                            acc_f3_next   = f3;
                            mem_raddr     = ld_addr[ADDR_W+1:2];
                            state_next    = S_LD1;
                        end
                    end
                    OPC_STORE:
                    begin
                        if (f3 > LD_W)
                        begin
                            fin        = 1'b1;
                            fin_status = ST_ILLEGAL;
                        end
                        else if (!mem_ok(st_addr, size_bytes(f3[1:0])))
                        begin
                            fin        = 1'b1;
                            fin_status = ST_SFAULT;
                        end
                        else
                        begin
                            acc_addr_next = st_addr;
                            acc_mask_next = byte_mask(f3[1:0], st_addr[1:0]);
                            st_data_next  = b;
                            clr_pass_next = 1'b0;
                            mem_raddr     = st_addr[ADDR_W+1:2];
                            state_next    = S_ST1;
                        end
                    end
                    OPC_JAL:
                    begin
                        wb_en   = 1'b1;
                        wb_val  = npc;
                        pc_next = pc_reg + imm_j(x);
                        fin     = 1'b1;
                    end
                    OPC_JALR:
                    begin
                        wb_en   = 1'b1;
                        wb_val  = npc;
                        pc_next = {ld_addr[31:1], 1'b0};
                        fin     = 1'b1;
                    end
                    OPC_BRANCH:
                    begin
                        fin = 1'b1;
                        case (f3)
                            BR_EQ:   taken = (a == b);
                            BR_NE:   taken = (a != b);
                            BR_LT:   taken = $signed(a) < $signed(b);
                            BR_GE:   taken = !($signed(a) < $signed(b));
                            BR_LTU:  taken = a < b;
                            BR_GEU:  taken = a >= b;
                            default: fin_status = ST_ILLEGAL;
                        endcase
                        if (fin_status == ST_ADV)
                        begin
                            pc_next = taken ? pc_reg + imm_b(x) : npc;
                        end
                    end
                    OPC_SYSTEM:
                    begin
                        fin = 1'b1;
                        if (x == INSN_EBREAK)
                        begin
                            fin_status = ST_HALT;
                        end
                        else if (x == INSN_ECALL)
                        begin
                            pc_next    = npc;
                            fin_status = ST_ECALL;
                        end
                        else if (x == INSN_MRET)
                        begin
                            pc_next = mepc_reg;
                        end
                        else if (f3 == SYS_PRIV || f3 == SYS_RSVD)
                        begin
                            // Vector to mtvec if one is set
                            mepc_next   = pc_reg;
                            mcause_next = CAUSE_ILLEGAL;
                            mtval_next  = x;
                            if (mtvec_reg != 32'd0)
                            begin
                                pc_next    = mtvec_reg;
                                fin_status = ST_TRAP;
                            end
                            else
                            begin
                                fin_status = ST_ILLEGAL;
                            end
                        end
                        else
                        begin
                            case (x[31:20])
                                CSR_MSTATUS: csr_old = mstatus_reg;
                                CSR_MTVEC:   csr_old = mtvec_reg;
                                CSR_MEPC:    csr_old = mepc_reg;
                                CSR_MCAUSE:  csr_old = mcause_reg;
                                CSR_MTVAL:   csr_old = mtval_reg;
                                default:     csr_old = 32'd0;
                            endcase
                            csr_src = f3[2] ? {27'b0, rs1} : a;
                            csr_wr  = (f3[1:0] == CSR_RW) || (rs1 != 5'd0);
                            case (f3[1:0])
                                CSR_RW:  csr_new = csr_src;
                                CSR_RS:  csr_new = csr_old | csr_src;
                                default: csr_new = csr_old & ~csr_src;
                            endcase
                            if (csr_wr)
                            begin
                                case (x[31:20])
                                    CSR_MSTATUS: mstatus_next = csr_new;
                                    CSR_MTVEC:   mtvec_next   = csr_new;
                                    CSR_MEPC:    mepc_next    = csr_new;
                                    CSR_MCAUSE:  mcause_next  = csr_new;
                                    CSR_MTVAL:   mtval_next   = csr_new;
                                    default:     mtval_next   = mtval_reg;
                                endcase
                            end
                            wb_en   = 1'b1;
                            wb_val  = csr_old;
                            pc_next = npc;
                        end
                    end
                    default:
                    begin
                        fin        = 1'b1;
                        fin_status = ST_ILLEGAL;
                    end
                endcase
            end
            S_MULDIV:
            begin
                if (md_done)
                begin
                    wb_en   = 1'b1;
                    wb_val  = md_value;
                    pc_next = npc;
                    fin     = 1'b1;
                end
            end
            S_LD1:
            begin
                if (acc_mask_reg[7:4] != 4'd0)
                begin
                    w0_next    = mem_rdata;
                    mem_raddr  = acc_idx1;
                    state_next = S_LD2;
                end
                else
                begin
                    wb_en   = 1'b1;
                    wb_val  = load_format(window_align({32'b0, mem_rdata},
                                                       acc_addr_reg[1:0]), acc_f3_reg);
                    pc_next = npc;
                    fin     = 1'b1;
                end
            end
            S_LD2:
            begin
                wb_en   = 1'b1;
                wb_val  = load_format(window_align({mem_rdata, w0_reg},
                                                   acc_addr_reg[1:0]), acc_f3_reg);
                pc_next = npc;
                fin     = 1'b1;
            end
            S_ST1:
            begin
                // Merge the low word; fetch the high word alongside if needed
                win       = window_merge({32'b0, mem_rdata}, st_data_reg,
                                         acc_addr_reg[1:0], acc_mask_reg);
                mem_we    = 1'b1;
                mem_waddr = acc_idx;
                mem_wdata = win[31:0];
                if (acc_mask_reg[7:4] != 4'd0)
                begin
                    mem_raddr  = acc_idx1;
                    state_next = S_ST2;
                end
                else
                begin
                    st_end = 1'b1;
                end
            end
            S_ST2:
            begin
                win       = window_merge({mem_rdata, 32'b0}, st_data_reg,
                                         acc_addr_reg[1:0], acc_mask_reg);
                mem_we    = 1'b1;
                mem_waddr = acc_idx1;
                mem_wdata = win[63:32];
                st_end    = 1'b1;
            end
            S_CLR:
            begin
                // Read the mailbox word only after the store has landed
                mem_raddr  = acc_idx;
                state_next = S_ST1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Resolve a completed store: exit, mailbox clear or advance
        if (st_end)
        begin
            if (clr_pass_reg)
            begin
                pc_next = npc;
                fin     = 1'b1;
            end
            else if (tohost_reg != 32'd0 && acc_addr_reg == tohost_reg)
            begin
                run_next   = RUN_EXITED;
                fin        = 1'b1;
                fin_status = ST_EXIT;
                fin_value  = st_data_reg;
            end
            else if (fromhost_reg != 32'd0 && acc_addr_reg == fromhost_reg
                     && st_data_reg != 32'd0 && mem_ok(fromhost_reg, 3'd4))
            begin
                acc_addr_next = fromhost_reg;
                acc_mask_next = byte_mask(LD_W[1:0], fromhost_reg[1:0]);
                st_data_next  = 32'd0;
                clr_pass_next = 1'b1;
                state_next    = S_CLR;
            end
            else
            begin
                pc_next = npc;
                fin     = 1'b1;
            end
        end

        // Write back the destination register
        if (wb_en && rd != 5'd0)
        begin
            rf_we     = 1'b1;
            rf_waddr  = rd;
            rf_wdata  = wb_val;
            fin_dest  = rd;
            fin_value = wb_val;
        end

        // Register the result transaction
        if (fin)
        begin
            done_next   = 1'b1;
            status_next = fin_status;
            dest_next   = fin_dest;
            value_next  = fin_value;
            state_next  = S_IDLE;
        end
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            run_reg      <= RUN_IDLE;
            pc_reg       <= 32'd0;
            mstatus_reg  <= 32'd0;
            mtvec_reg    <= 32'd0;
            mepc_reg     <= 32'd0;
            mcause_reg   <= 32'd0;
            mtval_reg    <= 32'd0;
            done_reg     <= 1'b0;
            clr_pass_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            run_reg      <= run_next;
            pc_reg       <= pc_next;
            mstatus_reg  <= mstatus_next;
            mtvec_reg    <= mtvec_next;
            mepc_reg     <= mepc_next;
            mcause_reg   <= mcause_next;
            mtval_reg    <= mtval_next;
            done_reg     <= done_next;
            clr_pass_reg <= clr_pass_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg    <= 32'd0;
            stack_reg    <= 32'd0;
            tohost_reg   <= 32'd0;
            fromhost_reg <= 32'd0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_ENTRY:  entry_reg    <= cfg_data;
                CFG_STACK:  stack_reg    <= cfg_data;
                CFG_TOHOST: tohost_reg   <= cfg_data;
                default:    fromhost_reg <= cfg_data;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        instr_reg    <= instr_next;
        w0_reg       <= w0_next;
        loc_ok_reg   <= loc_ok_next;
        acc_addr_reg <= acc_addr_next;
        acc_mask_reg <= acc_mask_next;
        acc_f3_reg   <= acc_f3_next;
        st_data_reg  <= st_data_next;
        status_reg   <= status_next;
        dest_reg     <= dest_next;
        value_reg    <= value_next;
    end

    rvex_mem #(
        .MEM_WORDS (MEM_WORDS),
        .ADDR_W    (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rvex_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .clear   (rf_clear),
        .we      (rf_we),
        .waddr   (rf_waddr),
        .wdata   (rf_wdata),
        .raddr_a (rf_raddr_a),
        .raddr_b (rf_raddr_b),
        .rdata_a (rf_rdata_a),
        .rdata_b (rf_rdata_b)
    );

    rvex_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .op_a  (a),
        .op_b  (b),
        .done  (md_done),
        .value (md_value)
    );

    assign busy            = (state_reg != S_IDLE);
    assign done            = done_reg;
    assign status          = status_reg;
    assign program_counter = pc_reg;
    assign dest_index      = dest_reg;
    assign result_value    = value_reg;

endmodule

[sim/rv32im_execute_core_tb.sv]
module rv32im_execute_core_tb;
    import rvex_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MEM_WORDS  = 16384;
    localparam int QUIET_MAX  = 2000;
    localparam int HOLD_OFF   = 40;
    localparam int PHASE_ITEMS = 280;

    // Divide and remainder funct3 codes of the M extension
    localparam logic [2:0] MD_DIV  = 3'd4;
    localparam logic [2:0] MD_DIVU = 3'd5;
    localparam logic [2:0] MD_REM  = 3'd6;
    localparam logic [2:0] MD_REMU = 3'd7;
    localparam logic [1:0] CSR_RC  = 2'd3;
    localparam logic [11:0] CSR_CUSTOM = 12'h7c0;

    typedef struct packed {
        logic [3:0]  st;
        logic [31:0] pc;
        logic [4:0]  rd;
        logic [31:0] val;
    } outcome_t;

    typedef struct {
        logic [1:0]  act;
        logic [15:0] loc;
        logic [31:0] w;
        bit          typed;
        outcome_t    want;
    } probe_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  action = ACT_STEP;
    logic [15:0] location = '0;
    logic [31:0] word = '0;
    logic        done;
    logic [3:0]  status;
    logic [31:0] program_counter;
    logic [4:0]  dest_index;
    logic [31:0] result_value;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = CFG_ENTRY;
    logic [31:0] cfg_data = '0;

    // Architectural state of the core as the testbench sees it
    logic [31:0] xreg [32];
    logic [31:0] pc_q;
    logic [31:0] mem_q [MEM_WORDS];
    bit          mem_set [MEM_WORDS];
    logic [31:0] csr_q [5];
    logic [1:0]  run_q;
    logic [31:0] cfg_q [4];
    logic [4:0]  o_rd;
    logic [31:0] o_val;

    outcome_t pending_results [$];
    int unsigned fails = 0;
    int unsigned quiet = 0;
    int unsigned sender_idle = 0;

    rv32im_execute_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .location        (location),
        .word            (word),
        .done            (done),
        .status          (status),
        .program_counter (program_counter),
        .dest_index      (dest_index),
        .result_value    (result_value),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic bit in_mem(input logic [31:0] a, input int n);
        return (64'(a) + 64'(n)) <= 64'(MEM_WORDS * 4);
    endfunction

    function automatic logic [31:0] read_bytes(input logic [31:0] a, input int n);
        logic [31:0] r;
        logic [31:0] b;
        r = '0;
        for (int i = 0; i < n; i++)
        begin
            b = a + i;
            r[8*i +: 8] = mem_q[b[31:2]][8*b[1:0] +: 8];
        end
        return r;
    endfunction

    function automatic void write_bytes(input logic [31:0] a, input int n, input logic [31:0] v);
        logic [31:0] b;
        if (!in_mem(a, n))
            return;
        for (int i = 0; i < n; i++)
        begin
            b = a + i;
            mem_q[b[31:2]][8*b[1:0] +: 8] = v[8*i +: 8];
        end
    endfunction

    function automatic void put_reg(input logic [4:0] i, input logic [31:0] v);
        if (i != 5'd0)
        begin
            xreg[i] = v;
            o_rd = i;
            o_val = v;
        end
    endfunction

    function automatic int csr_slot(input logic [11:0] a);
        case (a)
            CSR_MSTATUS: return 0;
            CSR_MTVEC:   return 1;
            CSR_MEPC:    return 2;
            CSR_MCAUSE:  return 3;
            CSR_MTVAL:   return 4;
            default:     return -1;
        endcase
    endfunction

    function automatic logic [31:0] mul_div(input logic [2:0] f3, input logic [31:0] a,
                                            input logic [31:0] b);
        logic [63:0] p;
        logic [31:0] hi;
        logic [31:0] ua;
        logic [31:0] ub;
        logic [31:0] q;
        p = {32'b0, a} * {32'b0, b};
        hi = p[63:32];
        ua = a[31] ? -a : a;
        ub = b[31] ? -b : b;
        case (f3)
            MD_MUL:    return p[31:0];
            MD_MULH:   return hi - (a[31] ? b : 32'd0) - (b[31] ? a : 32'd0);
            MD_MULHSU: return hi - (a[31] ? b : 32'd0);
            MD_MULHU:  return hi;
            MD_DIV:
            begin
                if (b == 0) return '1;
                if (a == 32'h8000_0000 && b == '1) return a;
                q = ua / ub;
                return (a[31] != b[31]) ? -q : q;
            end
            MD_DIVU:   return (b == 0) ? '1 : a / b;
            MD_REM:
            begin
                if (b == 0) return a;
                if (a == 32'h8000_0000 && b == '1) return '0;
                q = ua % ub;
                return a[31] ? -q : q;
            end
            default:   return (b == 0) ? a : a % b;
        endcase
    endfunction

    // Execute the instruction at the current pc and return the status
    function automatic logic [3:0] execute_insn();
        logic [31:0] x, a, b, v, npc, ad, im, old, nv, src;
        logic [6:0]  op, f7;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        int          s, n;
        bit          t;
        if (!in_mem(pc_q, 4))
            return ST_FFAULT;
        x = read_bytes(pc_q, 4);
        npc = pc_q + 32'd4;
        op = x[6:0];
        rd = x[11:7];
        f3 = x[14:12];
        rs1 = x[19:15];
        rs2 = x[24:20];
        f7 = x[31:25];
        a = xreg[rs1];
        b = xreg[rs2];
        im = {{20{x[31]}}, x[31:20]};
        case (op)
            OPC_LUI:   put_reg(rd, {x[31:12], 12'b0});
            OPC_AUIPC: put_reg(rd, pc_q + {x[31:12], 12'b0});
            OPC_OPIMM:
            begin
                case (f3)
                    F3_ADD:  v = a + im;
                    F3_SLL:  v = a << rs2;
                    F3_SLT:  v = ($signed(a) < $signed(im)) ? 32'd1 : 32'd0;
                    F3_SLTU: v = (a < im) ? 32'd1 : 32'd0;
                    F3_XOR:  v = a ^ im;
                    F3_SR:
                    begin
                        if (f7 == F7_BASE) v = a >> rs2;
                        else if (f7 == F7_ALT) v = $signed(a) >>> rs2;
                        else return ST_ILLEGAL;
                    end
                    F3_OR:   v = a | im;
                    default: v = a & im;
                endcase
                put_reg(rd, v);
            end
            OPC_OP:
            begin
                if (f7 == F7_MULDIV)
                    v = mul_div(f3, a, b);
                else if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  v = a + b;
                        F3_SLL:  v = a << b[4:0];
                        F3_SLT:  v = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
                        F3_SLTU: v = (a < b) ? 32'd1 : 32'd0;
                        F3_XOR:  v = a ^ b;
                        F3_SR:   v = a >> b[4:0];
                        F3_OR:   v = a | b;
                        default: v = a & b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD)
                    v = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR)
                    v = $signed(a) >>> b[4:0];
                else
                    return ST_ILLEGAL;
                put_reg(rd, v);
            end
            OPC_LOAD:
            begin
                ad = a + im;
                if (!(f3 inside {LD_B, LD_H, LD_W, LD_BU, LD_HU}))
                    return ST_ILLEGAL;
                n = (f3[1:0] == 2'd0) ? 1 : ((f3[1:0] == 2'd1) ? 2 : 4);
                if (!in_mem(ad, n))
                    return ST_LFAULT;
                v = read_bytes(ad, n);
                if (f3 == LD_B) v = {{24{v[7]}}, v[7:0]};
                else if (f3 == LD_H) v = {{16{v[15]}}, v[15:0]};
                put_reg(rd, v);
            end
            OPC_STORE:
            begin
                ad = a + {{20{x[31]}}, x[31:25], x[11:7]};
                if (f3 > LD_W)
                    return ST_ILLEGAL;
                n = 1 << f3;
                if (!in_mem(ad, n))
                    return ST_SFAULT;
                write_bytes(ad, n, b);
                if (cfg_q[CFG_TOHOST] != 0 && ad == cfg_q[CFG_TOHOST])
                begin
                    run_q = RUN_EXITED;
                    o_val = b;
                    return ST_EXIT;
                end
                if (cfg_q[CFG_FROMHOST] != 0 && ad == cfg_q[CFG_FROMHOST] && b != 0)
                    write_bytes(cfg_q[CFG_FROMHOST], 4, 32'd0);
            end
            OPC_JAL:
            begin
                put_reg(rd, npc);
                npc = pc_q + {{11{x[31]}}, x[31], x[19:12], x[20], x[30:21], 1'b0};
            end
            OPC_JALR:
            begin
                npc = (a + im) & ~32'd1;
                put_reg(rd, pc_q + 32'd4);
            end
            OPC_BRANCH:
            begin
                case (f3)
                    BR_EQ:   t = (a == b);
                    BR_NE:   t = (a != b);
                    BR_LT:   t = $signed(a) < $signed(b);
                    BR_GE:   t = !($signed(a) < $signed(b));
                    BR_LTU:  t = a < b;
                    BR_GEU:  t = a >= b;
                    default: return ST_ILLEGAL;
                endcase
                if (t)
                    npc = pc_q + {{19{x[31]}}, x[31], x[7], x[30:25], x[11:8], 1'b0};
            end
            OPC_SYSTEM:
            begin
                if (x == INSN_EBREAK)
                    return ST_HALT;
                if (x == INSN_ECALL)
                begin
                    pc_q = npc;
                    return ST_ECALL;
                end
                if (x == INSN_MRET)
                begin
                    pc_q = csr_q[2];
                    return ST_ADV;
                end
                // Other privileged or reserved SYSTEM encodings raise an illegal-instruction trap
                if (f3 == SYS_PRIV || f3 == SYS_RSVD)
                begin
                    csr_q[2] = pc_q;
                    csr_q[3] = CAUSE_ILLEGAL;
                    csr_q[4] = x;
                    if (csr_q[1] != 0)
                    begin
                        pc_q = csr_q[1];
                        return ST_TRAP;
                    end
                    return ST_ILLEGAL;
                end
                s = csr_slot(x[31:20]);
                old = (s >= 0) ? csr_q[s] : 32'd0;
                src = f3[2] ? {27'b0, rs1} : a;
                if (f3[1:0] == CSR_RW) nv = src;
                else if (f3[1:0] == CSR_RS) nv = old | src;
                else nv = old & ~src;
                if ((f3[1:0] == CSR_RW || rs1 != 0) && s >= 0)
                    csr_q[s] = nv;
                put_reg(rd, old);
            end
            default: return ST_ILLEGAL;
        endcase
        pc_q = npc;
        return ST_ADV;
    endfunction

    // Apply one transaction to the state and return the result it produces
    function automatic outcome_t retire_item(input logic [1:0] act, input logic [15:0] loc,
                                             input logic [31:0] w);
        logic [3:0] st;
        st = ST_ADV;
        o_rd = '0;
        o_val = '0;
        case (act)
            ACT_STEP: st = (run_q != RUN_READY) ? ST_NOTREADY : execute_insn();
            ACT_RESTART:
            begin
                foreach (xreg[i]) xreg[i] = '0;
                foreach (csr_q[i]) csr_q[i] = '0;
                pc_q = cfg_q[CFG_ENTRY];
                xreg[2] = cfg_q[CFG_STACK] & ~32'd15;
                run_q = RUN_READY;
            end
            ACT_LOAD:
            begin
                mem_q[loc[15:2]] = w;
                mem_set[loc[15:2]] = 1'b1;
                o_val = w;
            end
            default: o_val = (loc < 16'd32) ? xreg[loc[4:0]] : 32'd0;
        endcase
        return '{st, pc_q, o_rd, o_val};
    endfunction

    // Hand one transaction to the core and record what it should return
    task automatic issue(input logic [1:0] act, input logic [15:0] loc, input logic [31:0] w,
                         input bit typed, input outcome_t want);
        outcome_t got;
        if ($urandom_range(0, 99) < sender_idle)
        begin
            repeat ($urandom_range(1, 4)) @(negedge clk) start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        action <= act;
        location <= loc;
        word <= w;
        @(posedge clk);
        while (busy) @(posedge clk);
        got = retire_item(act, loc, w);
        pending_results.push_back(typed ? want : got);
    endtask

    // Make every word the step touches defined, place the instruction, then step
    task automatic place_and_step(input logic [31:0] insn, input bit typed, input outcome_t want);
        logic [31:0] ad;
        logic [31:0] wi;
        logic [31:0] r;
        logic [63:0] win;
        if (run_q == RUN_READY)
        begin
            if (insn[6:0] == OPC_LOAD || insn[6:0] == OPC_STORE)
            begin
                ad = xreg[insn[19:15]] + ((insn[6:0] == OPC_LOAD) ?
                     {{20{insn[31]}}, insn[31:20]} :
                     {{20{insn[31]}}, insn[31:25], insn[11:7]});
                for (int k = 0; k < 2; k++)
                begin
                    wi = (ad + 32'(3 * k)) >> 2;
                    r = $urandom;
                    if (wi < MEM_WORDS && !mem_set[wi])
                        issue(ACT_LOAD, {wi[13:0], r[1:0]}, $urandom, 1'b0, '0);
                end
            end
            if (in_mem(pc_q, 4))
            begin
                wi = pc_q >> 2;
                r = $urandom;
                if (pc_q[1:0] == 2'd0)
                    issue(ACT_LOAD, {wi[13:0], r[1:0]}, insn, 1'b0, '0);
                else
                begin
                    win = {(mem_set[wi + 1] ? mem_q[wi + 1] : $urandom),
                           (mem_set[wi] ? mem_q[wi] : $urandom)};
                    win[8*pc_q[1:0] +: 32] = insn;
                    issue(ACT_LOAD, {wi[13:0], r[1:0]}, win[31:0], 1'b0, '0);
                    wi = wi + 1;
                    issue(ACT_LOAD, {wi[13:0], r[3:2]}, win[63:32], 1'b0, '0);
                end
            end
        end
        issue(ACT_STEP, 16'($urandom), $urandom, typed, want);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        cfg_q[idx] = val;
    endtask

    // Drain the core, then load a new configuration
    task automatic program_config(input logic [31:0] e, input logic [31:0] s,
                                  input logic [31:0] t, input logic [31:0] f);
        @(negedge clk) start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
        write_cfg(CFG_ENTRY, e);
        write_cfg(CFG_STACK, s);
        write_cfg(CFG_TOHOST, t);
        write_cfg(CFG_FROMHOST, f);
        @(negedge clk) cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] enc_i(input logic [11:0] imm, input logic [4:0] rs1,
                                          input logic [2:0] f3, input logic [4:0] rd,
                                          input logic [6:0] op);
        return {imm, rs1, f3, rd, op};
    endfunction

    function automatic logic [31:0] enc_r(input logic [6:0] f7, input logic [4:0] rs2,
                                          input logic [4:0] rs1, input logic [2:0] f3,
                                          input logic [4:0] rd);
        return {f7, rs2, rs1, f3, rd, OPC_OP};
    endfunction

    // Pick a base and offset that mostly land in the low part of memory
    function automatic logic [16:0] pick_base();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 5))
            0, 1, 2: return {5'd0, 1'b0, 11'($urandom_range(0, 2047))};
            3:       return {5'd2, r[11:0]};
            default: return {r[16:12], r[11:0]};
        endcase
    endfunction

    // Draw a random instruction, weighted towards forms that keep the core running
    function automatic logic [31:0] gen_insn();
        logic [31:0] r;
        logic [4:0]  rd, rs1, rs2;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [16:0] bs;
        logic [11:0] im;
        logic [12:0] boff;
        logic [20:0] joff;
        r = $urandom;
        rd = $urandom_range(0, 31);
        rs1 = $urandom_range(0, 31);
        rs2 = $urandom_range(0, 31);
        f3 = $urandom_range(0, 7);
        case ($urandom_range(0, 11))
            0: return {r[31:12], rd, r[0] ? OPC_LUI : OPC_AUIPC};
            1, 2:
            begin
                if (f3 != F3_SR)
                    return enc_i(r[31:20], rs1, f3, rd, OPC_OPIMM);
                f7 = ($urandom_range(0, 7) == 0) ? r[31:25] : (r[0] ? F7_ALT : F7_BASE);
                return {f7, rs2, rs1, f3, rd, OPC_OPIMM};
            end
            3, 4:
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: f7 = F7_BASE;
                    4, 5:       f7 = F7_ALT;
                    6, 7, 8:    f7 = F7_MULDIV;
                    default:    f7 = r[31:25];
                endcase
                return enc_r(f7, rs2, rs1, f3, rd);
            end
            5:
            begin
                bs = pick_base();
                return enc_i(bs[11:0], bs[16:12], f3, rd, OPC_LOAD);
            end
            6:
            begin
                bs = pick_base();
                f3 = ($urandom_range(0, 5) == 0) ? 3'($urandom_range(3, 7)) :
                     3'($urandom_range(0, 2));
                // Aim a good share of stores at the host mailboxes
                if ($urandom_range(0, 2) == 0)
                begin
                    im = r[0] ? cfg_q[CFG_TOHOST][11:0] : cfg_q[CFG_FROMHOST][11:0];
                    bs = {5'd0, im[11] ? r[11:0] : im};
                end
                return {bs[11:5], rs2, bs[16:12], f3, bs[4:0], OPC_STORE};
            end
            7:
            begin
                joff = 21'((int'($urandom_range(0, 128)) - 64) * 2);
                return {joff[20], joff[10:1], joff[11], joff[19:12], rd, OPC_JAL};
            end
            8:
            begin
                if ($urandom_range(0, 3) == 0)
                    return enc_i(r[31:20], rs1, 3'd0, rd, OPC_JALR);
                return enc_i(12'($urandom_range(0, 2047)), 5'd0, 3'd0, rd, OPC_JALR);
            end
            9:
            begin
                boff = 13'((int'($urandom_range(0, 128)) - 64) * 2);
                return {boff[12], boff[10:5], rs2, rs1, f3, boff[4:1], boff[11], OPC_BRANCH};
            end
            10:
            begin
                if (f3 == SYS_PRIV || f3 == SYS_RSVD)
                    f3 = {f3[2], CSR_RW};
                case ($urandom_range(0, 6))
                    0: im = CSR_MSTATUS;
                    1: im = CSR_MTVEC;
                    2: im = CSR_MEPC;
                    3: im = CSR_MCAUSE;
                    4: im = CSR_MTVAL;
                    default: im = r[31:20];
                endcase
                return enc_i(im, rs1, f3, rd, OPC_SYSTEM);
            end
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return INSN_ECALL;
                    1: return INSN_EBREAK;
                    2: return INSN_MRET;
                    3: return {r[31:15], r[0] ? SYS_RSVD : SYS_PRIV, r[11:7], OPC_SYSTEM};
                    default: return r;
                endcase
            end
        endcase
    endfunction

    function automatic probe_t row(input logic [1:0] act, input logic [15:0] loc,
                                   input logic [31:0] w, input bit typed,
                                   input logic [3:0] st, input logic [31:0] pc,
                                   input logic [4:0] rd, input logic [31:0] val);
        probe_t p;
        p.act = act;
        p.loc = loc;
        p.w = w;
        p.typed = typed;
        p.want = '{st, pc, rd, val};
        return p;
    endfunction

    // Compare each result strobe with the oldest outstanding transaction
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no transaction outstanding");
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.st)
                begin
                    $error("status expected %0d got %0d", want.st, status);
                    fails++;
                end
                if (program_counter !== want.pc)
                begin
                    $error("program_counter expected %h got %h", want.pc, program_counter);
                    fails++;
                end
                if (dest_index !== want.rd)
                begin
                    $error("dest_index expected %0d got %0d", want.rd, dest_index);
                    fails++;
                end
                if (result_value !== want.val)
                begin
                    $error("result_value expected %h got %h", want.val, result_value);
                    fails++;
                end
            end
        end
    end

    // Stop a run that makes no progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin
        probe_t tab [$];
        logic [31:0] r;
        int n_items;
        foreach (xreg[i]) xreg[i] = '0;
        foreach (csr_q[i]) csr_q[i] = '0;
        foreach (cfg_q[i]) cfg_q[i] = '0;
        foreach (mem_set[i]) mem_set[i] = 1'b0;
        pc_q = '0;
        run_q = RUN_IDLE;

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        // Directed rows: extremes and special cases, with obvious results typed in
        tab.push_back(row(ACT_STEP, 16'h0, 32'h0, 1, ST_NOTREADY, 32'h0, 5'd0, 32'h0));
        tab.push_back(row(ACT_READ, 16'hffff, 32'h0, 1, ST_ADV, 32'h0, 5'd0, 32'h0));
        tab.push_back(row(ACT_LOAD, 16'hffff, 32'hffff_ffff, 1, ST_ADV, 32'h0, 5'd0,
                          32'hffff_ffff));
        tab.push_back(row(ACT_RESTART, 16'h0, 32'h0, 1, ST_ADV, 32'h0, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, {20'h80000, 5'd1, OPC_LUI}, 0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_i(12'hfff, 5'd0, F3_ADD, 5'd3, OPC_OPIMM),
                          0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_r(F7_MULDIV, 5'd3, 5'd1, MD_DIV, 5'd4),
                          0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_r(F7_MULDIV, 5'd3, 5'd1, MD_REM, 5'd5),
                          0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_r(F7_MULDIV, 5'd0, 5'd1, MD_DIVU, 5'd6),
                          1, ST_ADV, 32'h14, 5'd6, 32'hffff_ffff));
        tab.push_back(row(ACT_STEP, 0, enc_r(F7_MULDIV, 5'd0, 5'd1, MD_REMU, 5'd7),
                          1, ST_ADV, 32'h18, 5'd7, 32'h8000_0000));
        tab.push_back(row(ACT_STEP, 0, enc_r(F7_MULDIV, 5'd3, 5'd1, MD_MULH, 5'd8),
                          0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_r(F7_ALT, 5'd3, 5'd1, F3_SR, 5'd9), 0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_i(12'h0, 5'd0, SYS_RSVD, 5'd0, OPC_SYSTEM),
                          1, ST_ILLEGAL, 32'h20, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, enc_i(CSR_MTVEC, 5'd16, {1'b1, CSR_RW}, 5'd0,
                          OPC_SYSTEM), 0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_i(12'h0, 5'd0, SYS_RSVD, 5'd0, OPC_SYSTEM),
                          1, ST_TRAP, 32'h10, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, enc_i(CSR_CUSTOM, 5'd3, {1'b0, CSR_RS}, 5'd11,
                          OPC_SYSTEM), 0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_i(CSR_MEPC, 5'd0, {1'b0, CSR_RC}, 5'd12,
                          OPC_SYSTEM), 0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, INSN_MRET, 1, ST_ADV, 32'h24, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, INSN_ECALL, 1, ST_ECALL, 32'h28, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, INSN_EBREAK, 1, ST_HALT, 32'h28, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, 32'hffff_ffff, 1, ST_ILLEGAL, 32'h28, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, enc_i(12'hffc, 5'd0, LD_W, 5'd12, OPC_LOAD),
                          1, ST_LFAULT, 32'h28, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, {7'h7f, 5'd3, 5'd0, LD_W, 5'h1c, OPC_STORE},
                          1, ST_SFAULT, 32'h28, 5'd0, 32'h0));
        tab.push_back(row(ACT_STEP, 0, enc_r(F7_ALT, 5'd3, 5'd1, F3_SLL, 5'd10),
                          1, ST_ILLEGAL, 32'h28, 5'd0, 32'h0));
        tab.push_back(row(ACT_READ, 16'd9, 32'h0, 0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, enc_i(12'h0, 5'd1, 3'd0, 5'd13, OPC_JALR),
                          0, 0, 0, 0, 0));
        tab.push_back(row(ACT_STEP, 0, 32'h0, 1, ST_FFAULT, 32'h8000_0000, 5'd0, 32'h0));

        sender_idle = 32;
        foreach (tab[i])
        begin
            if (tab[i].act == ACT_STEP)
                place_and_step(tab[i].w, tab[i].typed, tab[i].want);
            else
                issue(tab[i].act, tab[i].loc, tab[i].w, tab[i].typed, tab[i].want);
        end

        // Random phases, each under its own configuration
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: program_config(32'h100, 32'h8000, 32'h7f0, 32'h7f8);
                1: program_config('1, '1, '1, '1);
                2: program_config(32'hfffc, 32'h0, 32'h0, 32'h0);
                default: program_config(32'($urandom_range(0, 2047)) & ~32'd3, $urandom,
                                        32'($urandom_range(1, 2047)),
                                        32'($urandom_range(1, 2047)));
            endcase
            sender_idle = (ph < 2) ? 32 : ((ph < 4) ? 51 : 0);
            n_items = (ph == 1) ? 60 : PHASE_ITEMS;
            for (int i = 0; i < n_items; i++)
            begin
                r = $urandom;
                if (run_q != RUN_READY && r[2:0] != 3'd0)
                    issue(ACT_RESTART, r[31:16], $urandom, 1'b0, '0);
                else if (r[7:0] < 8'd8)
                    issue(ACT_RESTART, r[31:16], $urandom, 1'b0, '0);
                else if (r[7:0] < 8'd20)
                    issue(ACT_READ, r[8] ? r[31:16] : {11'b0, r[20:16]}, $urandom, 1'b0, '0);
                else if (r[7:0] < 8'd32)
                    issue(ACT_LOAD, r[31:16], $urandom, 1'b0, '0);
                else
                    place_and_step(gen_insn(), 1'b0, '0);
            end
        end

        // Drain, let the core settle, then report
        @(negedge clk) start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[sim.f]
sv/rvex_pkg.sv
sv/rvex_mem.sv
sv/rvex_regfile.sv
sv/rvex_muldiv.sv
sv/rv32im_execute_core.sv
sim/rv32im_execute_core_tb.sv
